### rtl/i128d_pkg.sv
// types and constants shared by the signed 128-bit divider
// no dependencies; imported by every module of the block
package i128d_pkg;

   localparam int WIDE_W = 128;
   localparam int HALF_W = 64;
   localparam int CNT_W  = $clog2(WIDE_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WIDE_W - 1);
   localparam logic [HALF_W-1:0] MIN_UPPER = {1'b1, {(HALF_W-1){1'b0}}};

   typedef struct packed {
      logic signed [HALF_W-1:0] dividend_upper;
      logic [HALF_W-1:0]        dividend_lower;
      logic signed [HALF_W-1:0] divisor_upper;
      logic [HALF_W-1:0]        divisor_lower;
   } req_type;

   typedef struct packed {
      logic signed [HALF_W-1:0] quotient_upper;
      logic [HALF_W-1:0]        quotient_lower;
      logic signed [HALF_W-1:0] remainder_upper;
      logic [HALF_W-1:0]        remainder_lower;
      logic [1:0]               status;
   } rsp_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_DIV_ZERO    = 2'd1,
      STATUS_MIN_OPERAND = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ABS_NUM,
      ST_ABS_DEN,
      ST_DIVIDE,
      ST_FIX_QUO,
      ST_FIX_REM,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_NEG_NUM,
      OP_NEG_DEN,
      OP_DIV_STEP,
      OP_NEG_QUO,
      OP_NEG_REM
   } op_type;

   typedef struct packed {
      logic   busy;
      logic   load;
      op_type op;
      logic   done;
   } ctrl_type;

endpackage

### rtl/i128d_sub_unit.sv
// shared 128-bit subtractor with borrow out
// used for negation and for the restoring trial subtract; uses i128d_pkg
module i128d_sub_unit (
   input  logic [i128d_pkg::WIDE_W-1:0] a,
   input  logic [i128d_pkg::WIDE_W-1:0] b,
   output logic [i128d_pkg::WIDE_W-1:0] diff,
   output logic                         borrow
);
   import i128d_pkg::*;

   assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

### rtl/i128d_ctrl.sv
// sequencer for the divider: operand fixup, step count, result strobe
// uses i128d_pkg
module i128d_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                special,
   output i128d_pkg::ctrl_type ctrl
);
   import i128d_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (start) begin
               state_in = special ? ST_DONE : ST_ABS_NUM;
            end
         end
         ST_ABS_NUM: state_in = ST_ABS_DEN;
         ST_ABS_DEN: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_FIX_QUO;
            end
         end
         ST_FIX_QUO: state_in = ST_FIX_REM;
         ST_FIX_REM: state_in = ST_DONE;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl.busy = (state_ff != ST_IDLE);
      ctrl.load = (state_ff == ST_IDLE) && start;
      ctrl.done = (state_ff == ST_DONE);
      case (state_ff)
         ST_ABS_NUM: ctrl.op = OP_NEG_NUM;
         ST_ABS_DEN: ctrl.op = OP_NEG_DEN;
         ST_DIVIDE:  ctrl.op = OP_DIV_STEP;
         ST_FIX_QUO: ctrl.op = OP_NEG_QUO;
         ST_FIX_REM: ctrl.op = OP_NEG_REM;
         default:    ctrl.op = OP_NONE;
      endcase
   end

endmodule

### rtl/int128_signed_divide_remainder.sv
// signed 128-bit divider with remainder, top level
// uses i128d_pkg, i128d_ctrl and i128d_sub_unit
//
//   channel  ports                   handshake
//   request  start, busy, req_data   word taken when start high and busy low
//   result   rsp_strobe, rsp_data    word valid for one cycle, cannot be held
//
// a normal word passes from accept to strobe through ST_ABS_NUM and
// ST_ABS_DEN (operand magnitudes), 128 restoring steps on the shared
// subtractor (one quotient bit each), ST_FIX_QUO and ST_FIX_REM (sign fixup)
// and ST_DONE; a zero divisor or a -2^127 operand skips to the strobe cycle
// busy stays high until the strobe cycle ends; reset is synchronous and
// returns the sequencer to idle
module int128_signed_divide_remainder (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  i128d_pkg::req_type req_data,
   output logic               rsp_strobe,
   output i128d_pkg::rsp_type rsp_data
);
   import i128d_pkg::*;

   ctrl_type ctrl;

   // dividend magnitude shifts out at the top while quotient bits shift in
   logic [WIDE_W-1:0] num_ff;
   logic [WIDE_W-1:0] rem_ff;
   logic [WIDE_W-1:0] den_ff;
   logic              num_neg_ff;
   logic              den_neg_ff;
   status_type        status_ff;

   logic [WIDE_W-1:0] op_a, op_b, diff;
   logic              borrow;
   logic              div_zero, num_min, den_min, special;
   logic [WIDE_W-1:0] trial;

   // operand screening at accept
   assign div_zero = (req_data.divisor_upper == '0) && (req_data.divisor_lower == '0);
   assign num_min  = (req_data.dividend_upper == MIN_UPPER) && (req_data.dividend_lower == '0);
   assign den_min  = (req_data.divisor_upper == MIN_UPPER) && (req_data.divisor_lower == '0);
   assign special  = div_zero || num_min || den_min;

   i128d_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .special (special),
      .ctrl    (ctrl)
   );

   // shifted partial remainder with next dividend bit brought in
   assign trial = {rem_ff[WIDE_W-2:0], num_ff[WIDE_W-1]};

   // operand select for the shared subtractor
   always_comb begin
      case (ctrl.op)
         OP_NEG_NUM: begin
            op_a = '0;
            op_b = num_ff;
         end
         OP_NEG_DEN: begin
            op_a = '0;
            op_b = den_ff;
         end
         OP_DIV_STEP: begin
            op_a = trial;
            op_b = den_ff;
         end
         OP_NEG_QUO: begin
            op_a = '0;
            op_b = num_ff;
         end
         OP_NEG_REM: begin
            op_a = '0;
            op_b = rem_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   i128d_sub_unit u_sub (
      .a      (op_a),
      .b      (op_b),
      .diff   (diff),
      .borrow (borrow)
   );

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         num_neg_ff <= req_data.dividend_upper[HALF_W-1];
         den_neg_ff <= req_data.divisor_upper[HALF_W-1];
         rem_ff     <= '0;
         if (special) begin
            // special cases report all-zero results
            num_ff <= '0;
            den_ff <= '0;
         end else begin
            num_ff <= {req_data.dividend_upper, req_data.dividend_lower};
            den_ff <= {req_data.divisor_upper, req_data.divisor_lower};
         end
         if (div_zero) begin
            status_ff <= STATUS_DIV_ZERO;
         end else if (num_min || den_min) begin
            status_ff <= STATUS_MIN_OPERAND;
         end else begin
            status_ff <= STATUS_OK;
         end
      end else begin
         case (ctrl.op)
            OP_NEG_NUM: begin
               if (num_neg_ff) begin
                  num_ff <= diff;
               end
            end
            OP_NEG_DEN: begin
               if (den_neg_ff) begin
                  den_ff <= diff;
               end
            end
            OP_DIV_STEP: begin
               // restore on borrow, otherwise keep the difference
               rem_ff <= borrow ? trial : diff;
               num_ff <= {num_ff[WIDE_W-2:0], ~borrow};
            end
            OP_NEG_QUO: begin
               if (num_neg_ff != den_neg_ff) begin
                  num_ff <= diff;
               end
            end
            OP_NEG_REM: begin
               // remainder follows the dividend's sign
               if (num_neg_ff) begin
                  rem_ff <= diff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign busy       = ctrl.busy;
   assign rsp_strobe = ctrl.done;

   always_comb begin
      rsp_data.quotient_upper  = num_ff[WIDE_W-1:HALF_W];
      rsp_data.quotient_lower  = num_ff[HALF_W-1:0];
      rsp_data.remainder_upper = rem_ff[WIDE_W-1:HALF_W];
      rsp_data.remainder_lower = rem_ff[HALF_W-1:0];
      rsp_data.status          = status_ff;
   end

endmodule

### rtl/i128d_checker.sv
// port-level checks for the signed 128-bit divider, bound to the top level
// uses i128d_pkg
module i128d_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input i128d_pkg::req_type req_data,
   input logic               rsp_strobe,
   input i128d_pkg::rsp_type rsp_data
);
   import i128d_pkg::*;

   // an accepted word makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // a result word is only shown while busy
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   // after a result the block is free again and the strobe is single
   a_strobe_release: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!busy && !rsp_strobe))
      else $error("block not released after result");

   // error status words carry zero quotient and remainder
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status != STATUS_OK)) |->
         (rsp_data.quotient_upper == '0 && rsp_data.quotient_lower == '0 &&
          rsp_data.remainder_upper == '0 && rsp_data.remainder_lower == '0))
      else $error("error result with nonzero fields");

   // a zero divisor accepted at idle is answered in the very next cycle
   a_zero_div: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.divisor_upper == '0 && req_data.divisor_lower == '0)
         |=> ##0 (rsp_strobe && rsp_data.status == STATUS_DIV_ZERO))
      else $error("zero divisor not reported");

endmodule

bind int128_signed_divide_remainder i128d_checker u_i128d_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
